### design/paq_pkg.sv
// ---------------------------------------------------------------------------
// paq_pkg: shared types and constants of the priority admission queue
// Action and status codes, queue entry layout, register indexes and reset
// values, and the sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none

package paq_pkg;

   // request actions
   typedef enum logic [2:0] {
      ACT_RESERVE  = 3'd0,
      ACT_RELEASE  = 3'd1,
      ACT_SUBMIT   = 3'd2,
      ACT_CANCEL   = 3'd3,
      ACT_DISPATCH = 3'd4
   } action_type;

   // response status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OOM     = 3'd1,
      ST_BUSY    = 3'd2,
      ST_UNAVAIL = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   // control register indexes
   localparam logic [2:0] CSR_ACCEPTING     = 3'd0;
   localparam logic [2:0] CSR_STOPPING      = 3'd1;
   localparam logic [2:0] CSR_MAX_GRAPHS    = 3'd2;
   localparam logic [2:0] CSR_MAX_BYTES     = 3'd3;
   localparam logic [2:0] CSR_REQ_BYTE_LIM  = 3'd4;

   // control register reset values
   localparam logic [7:0]  RST_MAX_GRAPHS   = 8'd16;
   localparam logic [47:0] RST_MAX_BYTES    = 48'd268435456;
   localparam logic [47:0] RST_REQ_BYTE_LIM = 48'd67108864;

   // one queue entry as held in the entry memory
   typedef struct packed {
      logic [7:0] id;
      logic [1:0] prio;
      logic       cancelled;
      logic       fast_path;
   } entry_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CANCEL,
      S_FIND,
      S_SHIFT,
      S_REPLY
   } state_type;

   // cancelled entries rank as top priority
   function automatic logic [1:0] eff_prio(input entry_type e);
      eff_prio = e.cancelled ? 2'd0 : e.prio;
   endfunction

endpackage

`default_nettype wire

### design/paq_entry_ram.sv
// ---------------------------------------------------------------------------
// paq_entry_ram: queue entry memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module paq_entry_ram
   import paq_pkg::*;
#(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output entry_type              rd_data
);

   entry_type mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### design/priority_admission_queue_unit.sv
// ---------------------------------------------------------------------------
// priority_admission_queue_unit: admission control and bounded priority queue
// Reserve/release keep a byte and request budget; submit, cancel and dispatch
// work on a queue held in a single-port-read entry memory.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one action per transfer; rsp_* returns exactly one result
//   per request, in order. csr_* writes control registers (always ready) and
//   is to be written only while no request is in flight; the block itself
//   does not enforce this.
//   Reserve, release, submit and undefined actions: the request is decoded,
//   the result is registered in the reply state, and a new request is taken once the sequencer is back in idle.
//   Cancel: one memory read per queued entry, with the write-back overlapping
//   the next read.
//   Dispatch: one scan over the entry memory for the best entry, then one
//   pass that moves the later entries down, one entry per cycle.
//   One request is worked on at a time; req_ready is high only while idle.
//   When rsp_ready is low the finished result waits in the output register
//   and the sequencer holds before writing a newer one.
//   Reset empties the queue, clears the byte and request counts and loads
//   the register reset values; entry memory contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_admission_queue_unit
   import paq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [2:0]                           req_action,
   input  wire logic [7:0]                           req_request_id,
   input  wire logic [1:0]                           req_priority_req,
   input  wire logic                                 req_fast_path,
   input  wire logic [47:0]                          req_byte_count,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [2:0]                                rsp_status,
   output logic [7:0]                                rsp_out_id,
   output logic                                      rsp_out_cancelled,
   output logic                                      rsp_out_fast_path,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]          rsp_queued_count,
   output logic [47:0]                               rsp_reserved_total,
   output logic [7:0]                                rsp_admitted_count,
   // control register write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [47:0]                          csr_wdata
);

   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   // control registers
   logic        accepting_ff;
   logic        stopping_ff;
   logic [7:0]  max_graphs_ff;
   logic [47:0] max_bytes_ff;
   logic [47:0] byte_limit_ff;

   // sequencer and admission state
   state_type   state_ff, state_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [47:0] total_ff, total_in;
   logic [7:0]  adm_ff, adm_in;

   // captured request
   action_type  action_ff;
   logic [7:0]  id_ff;
   logic [1:0]  prio_ff;
   logic        dec_ff;
   logic [47:0] bytes_ff;

   // scan bookkeeping
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   entry_type        best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;

   // held result
   status_type  status_ff, status_in;
   logic [7:0]  oid_ff, oid_in;
   logic        ocan_ff, ocan_in;
   logic        odec_ff, odec_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type        ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   entry_type        cand;

   // shared conditions
   logic             req_xfer;
   logic             out_free;
   logic             scan_more;
   logic             take_cand;
   entry_type        fin_best;
   logic [IDX_W-1:0] fin_idx;
   logic [CNT_W-1:0] shift_first;
   logic             shift_more;
   logic             queue_full;
   logic             over_limit;
   logic             over_budget;
   logic [48:0]      budget_sum;
   logic [48:0]      release_diff;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // entry memory
   paq_entry_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (cand)
   );

   // admission checks: total + bytes above budget covers both the exhausted
   // budget and a request larger than what is left
   assign budget_sum   = {1'b0, total_ff} + {1'b0, bytes_ff};
   assign over_budget  = budget_sum > {1'b0, max_bytes_ff};
   assign over_limit   = bytes_ff > byte_limit_ff;
   assign queue_full   = len_ff >= CNT_W'(QUEUE_DEPTH);
   assign release_diff = {1'b0, total_ff} - {1'b0, bytes_ff};

   // best-entry tracking; the first entry read always starts the search
   assign scan_more   = scan_ff < len_ff;
   assign take_cand   = (pend_addr_ff == '0) || (eff_prio(cand) < eff_prio(best_ff));
   assign fin_best    = take_cand ? cand : best_ff;
   assign fin_idx     = take_cand ? pend_addr_ff : best_idx_ff;
   assign shift_first = CNT_W'(fin_idx) + CNT_W'(1);
   assign shift_more  = shift_first < len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (action_ff)
               ACT_CANCEL:   state_in = (len_ff == '0) ? S_REPLY : S_CANCEL;
               ACT_DISPATCH: state_in = (len_ff == '0) ? S_REPLY : S_FIND;
               default:      state_in = S_REPLY;
            endcase
         end
         S_CANCEL: begin
            if (!scan_more) state_in = S_REPLY;
         end
         S_FIND: begin
            if (!scan_more) state_in = shift_more ? S_SHIFT : S_REPLY;
         end
         S_SHIFT: begin
            if (!scan_more) state_in = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      len_in       = len_ff;
      total_in     = total_ff;
      adm_in       = adm_ff;
      scan_in      = scan_ff;
      pend_addr_in = pend_addr_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      status_in    = status_ff;
      oid_in       = oid_ff;
      ocan_in      = ocan_ff;
      odec_in      = odec_ff;
      ram_we       = 1'b0;
      ram_waddr    = pend_addr_ff;
      ram_wdata    = cand;
      ram_raddr    = '0;
      case (state_ff)
         S_DECODE: begin
            status_in = ST_OK;
            oid_in    = 8'd0;
            ocan_in   = 1'b0;
            odec_in   = 1'b0;
            case (action_ff)
               ACT_RESERVE: begin
                  if (over_limit) begin
                     status_in = ST_OOM;
                  end else if (!accepting_ff || queue_full) begin
                     status_in = ST_BUSY;
                  end else if ((adm_ff >= max_graphs_ff) || over_budget) begin
                     status_in = ST_BUSY;
                  end else begin
                     adm_in   = adm_ff + 8'd1;
                     total_in = budget_sum[47:0];
                  end
               end
               ACT_RELEASE: begin
                  total_in = release_diff[48] ? 48'd0 : release_diff[47:0];
                  if (adm_ff != 8'd0) adm_in = adm_ff - 8'd1;
               end
               ACT_SUBMIT: begin
                  if (!accepting_ff) begin
                     status_in = ST_UNAVAIL;
                  end else if (queue_full) begin
                     status_in = ST_BUSY;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = len_ff[IDX_W-1:0];
                     ram_wdata = '{id: id_ff, prio: prio_ff, cancelled: 1'b0,
                                   fast_path: dec_ff};
                     len_in    = len_ff + CNT_W'(1);
                  end
               end
               ACT_CANCEL: begin
                  ram_raddr    = '0;
                  scan_in      = CNT_W'(1);
                  pend_addr_in = '0;
               end
               ACT_DISPATCH: begin
                  if (len_ff == '0) status_in = ST_EMPTY;
                  ram_raddr    = '0;
                  scan_in      = CNT_W'(1);
                  pend_addr_in = '0;
               end
               default: ;
            endcase
         end
         // read each entry, write back the ones that match with the flag set
         S_CANCEL: begin
            if (cand.id == id_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = '{id: cand.id, prio: cand.prio, cancelled: 1'b1,
                             fast_path: cand.fast_path};
            end
            if (scan_more) begin
               ram_raddr    = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
               pend_addr_in = scan_ff[IDX_W-1:0];
            end
         end
         // search for the first entry of lowest effective priority
         S_FIND: begin
            best_in     = fin_best;
            best_idx_in = fin_idx;
            if (scan_more) begin
               ram_raddr    = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
               pend_addr_in = scan_ff[IDX_W-1:0];
            end else begin
               oid_in  = fin_best.id;
               ocan_in = fin_best.cancelled | stopping_ff;
               odec_in = fin_best.fast_path;
               if (shift_more) begin
                  ram_raddr    = shift_first[IDX_W-1:0];
                  scan_in      = shift_first + CNT_W'(1);
                  pend_addr_in = shift_first[IDX_W-1:0];
               end else begin
                  len_in = len_ff - CNT_W'(1);
               end
            end
         end
         // move each later entry down by one
         S_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_ff - IDX_W'(1);
            ram_wdata = cand;
            if (scan_more) begin
               ram_raddr    = scan_ff[IDX_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
               pend_addr_in = scan_ff[IDX_W-1:0];
            end else begin
               len_in = len_ff - CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   // output register handshake
   always_comb begin
      if ((state_ff == S_REPLY) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         total_ff     <= 48'd0;
         adm_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         total_ff     <= total_in;
         adm_ff       <= adm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         accepting_ff  <= 1'b1;
         stopping_ff   <= 1'b0;
         max_graphs_ff <= RST_MAX_GRAPHS;
         max_bytes_ff  <= RST_MAX_BYTES;
         byte_limit_ff <= RST_REQ_BYTE_LIM;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACCEPTING:    accepting_ff  <= csr_wdata[0];
            CSR_STOPPING:     stopping_ff   <= csr_wdata[0];
            CSR_MAX_GRAPHS:   max_graphs_ff <= csr_wdata[7:0];
            CSR_MAX_BYTES:    max_bytes_ff  <= csr_wdata;
            CSR_REQ_BYTE_LIM: byte_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         action_ff <= action_type'(req_action);
         id_ff     <= req_request_id;
         prio_ff   <= req_priority_req;
         dec_ff    <= req_fast_path;
         bytes_ff  <= req_byte_count;
      end
   end

   // scan and result holding registers
   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      pend_addr_ff <= pend_addr_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      status_ff    <= status_in;
      oid_ff       <= oid_in;
      ocan_ff      <= ocan_in;
      odec_ff      <= odec_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if ((state_ff == S_REPLY) && out_free) begin
         rsp_status          <= status_ff;
         rsp_out_id          <= oid_ff;
         rsp_out_cancelled   <= ocan_ff;
         rsp_out_fast_path   <= odec_ff;
         rsp_queued_count    <= len_ff;
         rsp_reserved_total  <= total_ff;
         rsp_admitted_count  <= adm_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### test/priority_admission_queue_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// priority_admission_queue_unit_test: self-checking bench for the admission queue
// Sends reserve, release, submit, cancel and dispatch requests over valid/ready
// and keeps its own copy of the byte budget, admitted count and request queue.
// Every response is compared field by field, in order, with the predicted
// one. Covers directed corners, register extremes, random traffic under
// several idle and stall mixes, and a long response hold-off.
// ---------------------------------------------------------------------------

module priority_admission_queue_unit_test
   import paq_pkg::*;
;

   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 280;
   localparam int PRESSURE_ITEMS = 60;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam logic [2:0] ACT_UNDEFINED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNDEFINED_LAST = 3'd7;
   localparam logic [47:0] ALL_ONES48 = '1;

   // one response as seen on the rsp_ side
   typedef struct packed {
      status_type         status;
      logic [7:0]         id;
      logic               cancelled;
      logic               fast_path;
      logic [COUNT_W-1:0] queued;
      logic [47:0]        reserved;
      logic [7:0]         admitted;
   } outcome_type;

   // block ports
   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic [2:0]         req_action = '0;
   logic [7:0]         req_request_id = '0;
   logic [1:0]         req_priority_req = '0;
   logic               req_fast_path = 1'b0;
   logic [47:0]        req_byte_count = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire [2:0]          rsp_status;
   wire [7:0]          rsp_out_id;
   wire                rsp_out_cancelled;
   wire                rsp_out_fast_path;
   wire [COUNT_W-1:0]  rsp_queued_count;
   wire [47:0]         rsp_reserved_total;
   wire [7:0]          rsp_admitted_count;
   logic               csr_valid = 1'b0;
   wire                csr_ready;
   logic [2:0]         csr_index = '0;
   logic [47:0]        csr_wdata = '0;

   // register copy, reset values
   logic               cfg_accepting = 1'b1;
   logic               cfg_stopping = 1'b0;
   logic [7:0]         cfg_max_graphs = RST_MAX_GRAPHS;
   logic [47:0]        cfg_max_bytes = RST_MAX_BYTES;
   logic [47:0]        cfg_byte_limit = RST_REQ_BYTE_LIM;

   // queue and budget copy
   entry_type          held_entries[$];
   logic [47:0]        bytes_reserved = '0;
   logic [7:0]         graphs_admitted = '0;

   outcome_type        expected_outcomes[$];
   outcome_type        observed;
   outcome_type        predicted;
   int                 failures = 0;
   int                 stuck_cycles = 0;
   int                 sender_idle_pct = 0;
   int                 receiver_stall_pct = 0;
   logic               holding = 1'b0;

   priority_admission_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_request_id(req_request_id),
      .req_priority_req(req_priority_req),
      .req_fast_path(req_fast_path),
      .req_byte_count(req_byte_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_out_id(rsp_out_id),
      .rsp_out_cancelled(rsp_out_cancelled),
      .rsp_out_fast_path(rsp_out_fast_path),
      .rsp_queued_count(rsp_queued_count),
      .rsp_reserved_total(rsp_reserved_total),
      .rsp_admitted_count(rsp_admitted_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [47:0] random_bytes48();
      logic [63:0] draw;
      draw = {$urandom, $urandom};
      return draw[47:0];
   endfunction

   // cancelled entries rank ahead of everything
   function automatic logic [1:0] effective_rank(input entry_type e);
      return e.cancelled ? 2'd0 : e.prio;
   endfunction

   // apply one request to the queue and budget copy, return its response
   function automatic outcome_type predict_outcome(input logic [2:0] action,
         input logic [7:0] id, input logic [1:0] prio, input logic dec,
         input logic [47:0] bytes);
      outcome_type result;
      entry_type   fresh;
      logic [47:0] room;
      int          best;
      result = '0;
      result.status = ST_OK;
      case (action)
         ACT_RESERVE: begin
            room = (bytes_reserved < cfg_max_bytes) ? cfg_max_bytes - bytes_reserved : '0;
            if (bytes > cfg_byte_limit) begin
               result.status = ST_OOM;
            end else if (!cfg_accepting || held_entries.size() >= QUEUE_DEPTH) begin
               result.status = ST_BUSY;
            end else if (graphs_admitted >= cfg_max_graphs || bytes_reserved > cfg_max_bytes
                         || bytes > room) begin
               result.status = ST_BUSY;
            end else begin
               graphs_admitted = graphs_admitted + 8'd1;
               bytes_reserved = bytes_reserved + bytes;
            end
         end
         ACT_RELEASE: begin
            bytes_reserved = (bytes_reserved > bytes) ? bytes_reserved - bytes : '0;
            if (graphs_admitted != 0)
               graphs_admitted = graphs_admitted - 8'd1;
         end
         ACT_SUBMIT: begin
            if (!cfg_accepting) begin
               result.status = ST_UNAVAIL;
            end else if (held_entries.size() >= QUEUE_DEPTH) begin
               result.status = ST_BUSY;
            end else begin
               fresh.id = id;
               fresh.prio = prio;
               fresh.cancelled = 1'b0;
               fresh.fast_path = dec;
               held_entries.push_back(fresh);
            end
         end
         ACT_CANCEL: begin
            foreach (held_entries[i])
               if (held_entries[i].id == id)
                  held_entries[i].cancelled = 1'b1;
         end
         ACT_DISPATCH: begin
            if (held_entries.size() == 0) begin
               result.status = ST_EMPTY;
            end else begin
               // first entry of the lowest rank wins
               best = 0;
               for (int i = 1; i < held_entries.size(); i++)
                  if (effective_rank(held_entries[i]) < effective_rank(held_entries[best]))
                     best = i;
               result.id = held_entries[best].id;
               result.cancelled = held_entries[best].cancelled | cfg_stopping;
               result.fast_path = held_entries[best].fast_path;
               held_entries.delete(best);
            end
         end
         default: ;
      endcase
      result.queued = COUNT_W'(held_entries.size());
      result.reserved = bytes_reserved;
      result.admitted = graphs_admitted;
      return result;
   endfunction

   // offer one request, optionally after an idle gap, and record its predicted response
   task automatic send_request(input logic [2:0] action, input logic [7:0] id,
         input logic [1:0] prio, input logic dec, input logic [47:0] bytes);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_request_id <= id;
      req_priority_req <= prio;
      req_fast_path <= dec;
      req_byte_count <= bytes;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_outcomes.push_back(predict_outcome(action, id, prio, dec, bytes));
   endtask

   // mostly well-formed traffic around a small id pool
   task automatic send_random_item();
      logic [2:0]  action;
      logic [7:0]  id;
      logic [47:0] bytes;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 22)
         action = ACT_RESERVE;
      else if (pick < 34)
         action = ACT_RELEASE;
      else if (pick < 60)
         action = ACT_SUBMIT;
      else if (pick < 70)
         action = ACT_CANCEL;
      else if (pick < 94)
         action = ACT_DISPATCH;
      else
         action = 3'($urandom_range(ACT_UNDEFINED_FIRST, ACT_UNDEFINED_LAST));
      id = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
      case ($urandom_range(9))
         0: bytes = '0;
         1: bytes = cfg_byte_limit;
         2: bytes = cfg_byte_limit + 48'd1;
         3: bytes = random_bytes48();
         4: bytes = ALL_ONES48;
         default: bytes = 48'(random_bytes48() % ({1'b0, cfg_byte_limit} + 49'd1));
      endcase
      send_request(action, id, 2'($urandom_range(3)), 1'($urandom_range(1)), bytes);
   endtask

   // drop valid and wait for every outstanding response
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
   endtask

   // one register transfer, valid left high for a following write
   task automatic write_reg(input logic [2:0] index, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_ACCEPTING:    cfg_accepting = data[0];
         CSR_STOPPING:     cfg_stopping = data[0];
         CSR_MAX_GRAPHS:   cfg_max_graphs = data[7:0];
         CSR_MAX_BYTES:    cfg_max_bytes = data;
         CSR_REQ_BYTE_LIM: cfg_byte_limit = data;
         default: ;
      endcase
   endtask

   // write all registers, unused upper bits filled with noise
   task automatic program_regs(input logic acc, input logic stop, input logic [7:0] maxg,
         input logic [47:0] maxb, input logic [47:0] lim);
      logic [47:0] junk;
      junk = random_bytes48();
      write_reg(CSR_ACCEPTING, {junk[47:1], acc});
      write_reg(CSR_STOPPING, {junk[46:0], stop});
      write_reg(CSR_MAX_GRAPHS, {junk[39:0], maxg});
      write_reg(CSR_MAX_BYTES, maxb);
      write_reg(CSR_REQ_BYTE_LIM, lim);
      csr_valid <= 1'b0;
   endtask

   // field extremes, every action and the queue corner cases at reset settings
   task automatic test_directed_basics();
      send_request(ACT_DISPATCH, 8'd0, 2'd0, 1'b0, '0);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, ALL_ONES48);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, RST_REQ_BYTE_LIM + 48'd1);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, ALL_ONES48);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, RST_REQ_BYTE_LIM);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, '0);
      send_request(ACT_SUBMIT, 8'd0, 2'd2, 1'b0, '0);
      send_request(ACT_SUBMIT, 8'd255, 2'd3, 1'b1, '0);
      send_request(ACT_SUBMIT, 8'hA5, 2'd1, 1'b1, '0);
      send_request(ACT_SUBMIT, 8'h5A, 2'd0, 1'b0, '0);
      send_request(ACT_SUBMIT, 8'd255, 2'd0, 1'b0, '0);
      // duplicate ids are both marked, a miss changes nothing
      send_request(ACT_CANCEL, 8'd255, 2'd0, 1'b0, '0);
      send_request(ACT_CANCEL, 8'h33, 2'd0, 1'b0, '0);
      repeat (5) send_request(ACT_DISPATCH, 8'd0, 2'd0, 1'b0, '0);
      for (int a = ACT_UNDEFINED_FIRST; a <= ACT_UNDEFINED_LAST; a++)
         send_request(3'(a), 8'($urandom_range(255)), 2'($urandom_range(3)),
                      1'($urandom_range(1)), random_bytes48());
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, RST_REQ_BYTE_LIM >> 1);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, ALL_ONES48);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, ALL_ONES48);
      wait_for_results();
   endtask

   // register extremes: closed, stopping, zero and full budgets, full queue
   task automatic test_register_extremes();
      // closed and stopping, with the graph and byte limits at zero
      write_reg(CSR_UNUSED, ALL_ONES48);
      program_regs(1'b0, 1'b1, 8'd0, '0, '0);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, '0);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, 48'd1);
      send_request(ACT_SUBMIT, 8'd1, 2'd1, 1'b1, '0);
      send_request(ACT_DISPATCH, 8'd0, 2'd0, 1'b0, '0);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, 48'd1);
      wait_for_results();

      // stopping reports every dispatch cancelled, zero graphs blocks reserve
      program_regs(1'b1, 1'b1, 8'd0, ALL_ONES48, ALL_ONES48);
      send_request(ACT_SUBMIT, 8'd7, 2'd1, 1'b1, '0);
      send_request(ACT_SUBMIT, 8'd9, 2'd2, 1'b0, '0);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, '0);
      repeat (2) send_request(ACT_DISPATCH, 8'd0, 2'd0, 1'b0, '0);
      wait_for_results();

      // fill the whole byte range
      program_regs(1'b1, 1'b0, 8'd255, ALL_ONES48, ALL_ONES48);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, ALL_ONES48);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, '0);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, 48'd1);
      wait_for_results();

      // budget already exceeded after lowering it
      program_regs(1'b1, 1'b0, 8'd255, 48'd1000, ALL_ONES48);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, '0);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, 48'd5);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, 48'h8000_0000_0000);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, ALL_ONES48);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, '0);
      wait_for_results();

      // single graph limit, then a full queue
      program_regs(1'b1, 1'b0, 8'd1, RST_MAX_BYTES, RST_REQ_BYTE_LIM);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, 48'd100);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, 48'd100);
      send_request(ACT_RELEASE, 8'd0, 2'd0, 1'b0, 48'd100);
      for (int n = 0; n < QUEUE_DEPTH; n++)
         send_request(ACT_SUBMIT, 8'(n), 2'(n), n[0], '0);
      send_request(ACT_SUBMIT, 8'd200, 2'd0, 1'b0, '0);
      send_request(ACT_RESERVE, 8'd0, 2'd0, 1'b0, '0);
      send_request(ACT_CANCEL, 8'd3, 2'd0, 1'b0, '0);
      repeat (QUEUE_DEPTH + 1) send_request(ACT_DISPATCH, 8'd0, 2'd0, 1'b0, '0);
      wait_for_results();
   endtask

   // random settings and random traffic under one idle/stall mix
   task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
      logic        acc;
      logic [7:0]  maxg;
      logic [47:0] budget;
      logic [47:0] limit;
      acc = ($urandom_range(7) != 0);
      maxg = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 12));
      budget = ($urandom_range(3) == 0) ? random_bytes48() : 48'($urandom_range(1, 1000000));
      limit = ($urandom_range(3) == 0) ? random_bytes48() : budget >> $urandom_range(0, 3);
      program_regs(acc, 1'($urandom_range(1)), maxg, budget, limit);
      sender_idle_pct = idle_pct;
      receiver_stall_pct <= stall_pct;
      repeat (items) send_random_item();
      wait_for_results();
   endtask

   // hold responses off for a long stretch while requests keep coming
   task automatic test_output_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct <= 0;
      fork
         begin
            holding <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            holding <= 1'b0;
         end
         repeat (PRESSURE_ITEMS) send_random_item();
      join
      wait_for_results();
   endtask

   // response ready with random stalls
   always @(posedge clock) begin
      if (reset || holding)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.status = status_type'(rsp_status);
         observed.id = rsp_out_id;
         observed.cancelled = rsp_out_cancelled;
         observed.fast_path = rsp_out_fast_path;
         observed.queued = rsp_queued_count;
         observed.reserved = rsp_reserved_total;
         observed.admitted = rsp_admitted_count;
         if (expected_outcomes.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: response with none outstanding, status %0d id %0d",
                        $realtime, rsp_status, rsp_out_id);
         end else begin
            predicted = expected_outcomes.pop_front();
            if (observed.status !== predicted.status || observed.id !== predicted.id
                || observed.cancelled !== predicted.cancelled
                || observed.fast_path !== predicted.fast_path
                || observed.queued !== predicted.queued
                || observed.reserved !== predicted.reserved
                || observed.admitted !== predicted.admitted) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("%0t: response mismatch", $realtime);
                  $display("  expected status %0d id %0d canc %0b fast %0b queued %0d",
                           predicted.status, predicted.id, predicted.cancelled,
                           predicted.fast_path, predicted.queued);
                  $display("           reserved %0d admitted %0d",
                           predicted.reserved, predicted.admitted);
                  $display("  actual   status %0d id %0d canc %0b fast %0b queued %0d",
                           rsp_status, rsp_out_id, rsp_out_cancelled,
                           rsp_out_fast_path, rsp_queued_count);
                  $display("           reserved %0d admitted %0d",
                           rsp_reserved_total, rsp_admitted_count);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_register_extremes();
      test_random_traffic(RANDOM_ITEMS, 0, 0);
      test_random_traffic(RANDOM_ITEMS, 80, 0);
      test_random_traffic(RANDOM_ITEMS, 0, 80);
      test_output_backpressure();
      test_random_traffic(RANDOM_ITEMS, 12, 12);
      // let any stray response show up
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && expected_outcomes.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
